// ===== hw/rtl/oftbl_pkg.sv =====
// Shared types, codes and the tag age compare for the oldest flush request table.
package oftbl_pkg;

    // Action codes of a request beat
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    localparam int TAG_W   = 7;
    localparam int PC_W    = 32;
    localparam int CKPT_W  = 4;
    localparam int COUNT_W = 4;

    typedef logic [COUNT_W-1:0] t_count;

    // Request beat
    typedef struct packed {
        logic [1:0]        action;
        logic [TAG_W-1:0]  tag;
        logic [PC_W-1:0]   restart_pc;
        logic [CKPT_W-1:0] checkpoint_id;
    } t_req;

    // Result beat
    typedef struct packed {
        logic              oldest_valid;
        logic [TAG_W-1:0]  oldest_tag;
        logic [PC_W-1:0]   oldest_pc;
        logic [CKPT_W-1:0] oldest_checkpoint;
        logic              overload;
        t_count            pending_count;
    } t_rsp;

    // One stored flush request
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PC_W-1:0]   pc;
        logic [CKPT_W-1:0] ckpt;
    } t_entry;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // Broadcast control to every cell
    typedef struct packed {
        logic   insert;
        logic   clear;
        t_entry item;
    } t_cell_ctl;

    // Ripple chain from cell to cell
    typedef struct packed {
        logic   search;   // all cells so far hold older requests
        logic   hole;     // an empty cell at or before this point
        logic   found;    // a valid entry seen so far
        t_entry best;     // oldest entry seen so far
    } t_link;

    // Wrap-bit age compare: a is strictly older than b
    function automatic logic tag_older(input logic [TAG_W-1:0] a, input logic [TAG_W-1:0] b);
        logic same_wrap;
        same_wrap = (a[TAG_W-1] == b[TAG_W-1]);
        if (same_wrap) begin
            return a[TAG_W-2:0] < b[TAG_W-2:0];
        end
        return a[TAG_W-2:0] > b[TAG_W-2:0];
    endfunction

endpackage

// ===== hw/rtl/oftbl_cell.sv =====
// One table cell: stores an entry, shifts on insert and collapse, feeds the oldest scan.
module oftbl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  oftbl_pkg::t_cell_ctl i_ctl,
    input  oftbl_pkg::t_slot     i_left,
    input  oftbl_pkg::t_slot     i_right,
    input  oftbl_pkg::t_link     i_link,
    output oftbl_pkg::t_slot     o_slot,
    output oftbl_pkg::t_link     o_link,
    output logic                 o_stall
);

    logic              r_valid;
    logic              n_valid;
    oftbl_pkg::t_entry r_entry;
    oftbl_pkg::t_entry n_entry;
    logic              older_here;
    logic              at_pos;
    logic              take_best;

    // Compare the stored tag against the broadcast tag
    assign older_here = oftbl_pkg::tag_older(r_entry.tag, i_ctl.item.tag);
    assign at_pos     = i_link.search & ~(r_valid & older_here);

    // Pass the chains on to the next cell
    assign take_best     = r_valid & (~i_link.found | oftbl_pkg::tag_older(r_entry.tag,
                                                                          i_link.best.tag));
    assign o_link.search = i_link.search & r_valid & older_here;
    assign o_link.hole   = i_link.hole | ~r_valid;
    assign o_link.found  = i_link.found | r_valid;
    assign o_link.best   = take_best ? r_entry : i_link.best;

    // A valid entry behind a gap means the table still needs compacting
    assign o_stall = i_link.hole & r_valid;

    assign o_slot.valid = r_valid;
    assign o_slot.entry = r_entry;

    // Pick the next cell contents
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (at_pos) begin
                n_valid = 1'b1;
                n_entry = i_ctl.item;
            end else if (!i_link.search) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end
        end else if (i_ctl.clear) begin
            if (r_valid && !older_here) begin
                n_valid = 1'b0;
            end
        end else if (o_link.hole) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the entry payload
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hw/rtl/oldest_flush_request_table.sv =====
// Top level: a row of cells holding flush requests sorted oldest first.
// The result beat is registered: a taken request sets a pending flag, which sets the strobe.
// Throughput: insert and query take one beat per cycle while busy is low; a clear that
// leaves gaps holds busy while the cell row collapses.
// Reset clears every valid flag at once; the table is empty and idle right after.
// The receiver cannot stall: each result beat is strobed for exactly one cycle.
module oldest_flush_request_table #(
    parameter int CAPACITY = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  oftbl_pkg::t_req i_req,
    output logic            o_strobe,
    output oftbl_pkg::t_rsp o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    oftbl_pkg::t_slot     w_slot  [CAPACITY];
    oftbl_pkg::t_slot     w_left  [CAPACITY];
    oftbl_pkg::t_slot     w_right [CAPACITY];
    oftbl_pkg::t_link     w_link  [CAPACITY+1];
    logic [CAPACITY-1:0]  w_stall;
    oftbl_pkg::t_cell_ctl w_ctl;
    logic                 w_accept;
    logic                 w_full;
    logic [CNT_W-1:0]     w_count;
    logic                 r_pend;
    logic                 r_ovl;
    logic                 n_ovl;
    logic                 r_strobe;
    oftbl_pkg::t_rsp      r_rsp;
    oftbl_pkg::t_rsp      n_rsp;

    assign busy     = |w_stall;
    assign w_accept = start & ~busy;
    assign w_full   = w_slot[CAPACITY-1].valid;

    // Decode the request beat into cell control
    always_comb begin
        w_ctl.insert = 1'b0;
        w_ctl.clear  = 1'b0;
        n_ovl        = 1'b0;
        w_ctl.item.tag  = i_req.tag;
        w_ctl.item.pc   = i_req.restart_pc;
        w_ctl.item.ckpt = i_req.checkpoint_id;
        case (i_req.action)
            oftbl_pkg::ACT_INSERT: begin
                w_ctl.insert = w_accept & ~w_full;
                n_ovl        = w_full;
            end
            oftbl_pkg::ACT_CLEAR: begin
                w_ctl.clear = w_accept;
            end
            default: begin
                n_ovl = 1'b0;
            end
        endcase
    end

    // Seed the ripple chain
    assign w_link[0].search = 1'b1;
    assign w_link[0].hole   = 1'b0;
    assign w_link[0].found  = 1'b0;
    assign w_link[0].best   = '0;

    // Build the cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid
            assign w_left[g] = w_slot[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_body
            assign w_right[g] = w_slot[g+1];
        end

        oftbl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_link  (w_link[g]),
            .o_slot  (w_slot[g]),
            .o_link  (w_link[g+1]),
            .o_stall (w_stall[g])
        );
    end

    // Count valid entries
    always_comb begin
        w_count = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_count = w_count + CNT_W'(w_slot[i].valid);
        end
    end

    // Form the result beat from the table after the request took effect
    always_comb begin
        n_rsp.oldest_valid      = w_link[CAPACITY].found;
        n_rsp.oldest_tag        = w_link[CAPACITY].best.tag;
        n_rsp.oldest_pc         = w_link[CAPACITY].best.pc;
        n_rsp.oldest_checkpoint = w_link[CAPACITY].best.ckpt;
        n_rsp.overload          = r_ovl;
        n_rsp.pending_count     = oftbl_pkg::t_count'(w_count);
    end

    // Track the request beat and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pend   <= w_accept;
            r_strobe <= r_pend;
        end
    end

    // Hold the overload flag and result payload
    always_ff @(posedge i_clk) begin
        r_ovl <= n_ovl;
        if (r_pend) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== hw/rtl/oftbl_checker.sv =====
// Port-level checks for the oldest flush request table, bound to the top level.
module oftbl_checker #(
    parameter int CAPACITY = 8
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input oftbl_pkg::t_req i_req,
    input logic            o_strobe,
    input oftbl_pkg::t_rsp o_rsp
);

    // Every taken request beat yields a result beat
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("request beat without result beat");

    // No result beat without a request beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result beat without request beat");

    // An empty table reports zero count, zero tag and zero pc
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.oldest_valid) |->
            (o_rsp.pending_count == '0 && o_rsp.oldest_tag == '0 && o_rsp.oldest_pc == '0))
        else $error("empty table result not zero");

    // A dropped insert means the table was full
    a_ovl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.overload) |->
            (o_rsp.pending_count == oftbl_pkg::t_count'(CAPACITY) && o_rsp.oldest_valid))
        else $error("overload with table not full");

    // Compaction only follows a clear
    a_busy_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_req.action == oftbl_pkg::ACT_CLEAR))
        else $error("busy without a clear beat");

endmodule

bind oldest_flush_request_table oftbl_checker #(.CAPACITY(CAPACITY)) u_oftbl_checker (.*);
